FILE: sv/text_console_writer_defines.svh
// Assertion macros shared by the text console writer RTL.
// Depends on clk_i and rst_ni being in scope where a macro is used.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define TCW_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define TCW_CHECK_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: sv/tcw_pkg.sv
// Package for the text console writer: geometry, codes, beat types and cell helper.
// No dependencies.
package tcw_pkg;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int TAB_SPACES  = 4;
  localparam int CELL_COUNT  = COLUMNS * ROWS;
  localparam int SCROLL_LAST = (ROWS - 1) * COLUMNS;

  localparam int CELL_W = 16;
  localparam int CHAR_W = 8;
  localparam int COLOR_W = 4;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CNT_W  = $clog2(CELL_COUNT + 1);
  localparam int TAB_W  = $clog2(TAB_SPACES + 1);
  localparam int CMD_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [COLOR_W-1:0] FG_RESET  = 4'hF;
  localparam logic [COLOR_W-1:0] BG_RESET  = 4'h0;
  localparam logic [CELL_W-1:0] RESET_BLANK = {BG_RESET, FG_RESET, BLANK_CHAR};

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } tcw_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOREGROUND = 2'd0,
    CFG_BACKGROUND = 2'd1
  } tcw_cfg_e;

  typedef enum logic [2:0] {
    OP_CHAR,
    OP_NEWLINE,
    OP_RETURN,
    OP_TAB,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } tcw_op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_TAB,
    ST_SCROLL,
    ST_CLEAR,
    ST_RDATA,
    ST_FINISH
  } tcw_state_e;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] character;
    logic [10:0]       cell_address;
  } tcw_in_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row_now;
    logic [COL_W-1:0]  column_now;
    logic [CELL_W-1:0] cell_data;
    logic              did_scroll;
  } tcw_out_t;

  typedef struct packed {
    tcw_op_e           op;
    logic [CHAR_W-1:0] character;
    logic [ADDR_W-1:0] cell_addr;
    logic              in_range;
  } tcw_op_t;

  // Head of the front queue as seen by the back end.
  typedef struct packed {
    logic    valid;
    tcw_op_t op;
  } tcw_head_t;

  // Back end status returned to the front end.
  typedef struct packed {
    logic take;
    logic init_busy;
  } tcw_status_t;

  typedef struct packed {
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
  } tcw_color_t;

  function automatic logic [CELL_W-1:0] make_cell(tcw_color_t col, logic [CHAR_W-1:0] ch);
    return {col.bg, col.fg, ch};
  endfunction

endpackage

FILE: sv/text_console_writer.sv
// Text console writer top level: color registers, front decode queue, back sequencer.
// Depends on tcw_pkg, tcw_front and tcw_back.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+-----------------------------
//   input    | push, full, in_item_i                   | beat when push && !full
//   result   | empty, pop, out_item_o                  | beat when pop && !empty
//   config   | cfg_valid_i, cfg_ready_o, cfg_index_i,  | beat when valid && ready;
//            | cfg_data_i                              | ready is always high
//
// Plain put, return, newline and unused commands finish in the cycle they are taken; a read
// finishes from ST_RDATA. Tab: take, four cell writes, finish. A scroll moves one store
// cell per cycle, then finishes from ST_FINISH after a put or newline or goes back to ST_TAB.
// Clear: 2000 cell writes on the store's single write port plus take and finish.
// After reset a clearing pass writes all 2000 cells with full high; config is taken as usual.
// A 2-entry front queue and a 1-entry result register let each side stall on its own.
module text_console_writer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  tcw_pkg::tcw_in_t               in_item_i,
  output logic                           empty,
  input  logic                           pop,
  output tcw_pkg::tcw_out_t              out_item_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tcw_pkg::COLOR_W-1:0]    cfg_data_i
);
  import tcw_pkg::*;

  tcw_color_t  color_q, color_d;
  tcw_head_t   head;
  tcw_status_t status;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    color_d = color_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FOREGROUND: color_d.fg = cfg_data_i;
        CFG_BACKGROUND: color_d.bg = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q.fg <= FG_RESET;
      color_q.bg <= BG_RESET;
    end else begin
      color_q <= color_d;
    end
  end

  tcw_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .in_item_i(in_item_i),
    .status_i (status),
    .head_o   (head)
  );

  tcw_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .color_i   (color_q),
    .status_o  (status),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item_o)
  );

endmodule

FILE: sv/tcw_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/tcw_front.sv
// Front end: accepts input beats, decodes them into operations, queues them for the back end.
// Depends on tcw_pkg.
module tcw_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  tcw_pkg::tcw_in_t     in_item_i,
  input  tcw_pkg::tcw_status_t status_i,
  output tcw_pkg::tcw_head_t   head_o
);
  import tcw_pkg::*;

  tcw_op_t             queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;
  logic                accept;
  tcw_op_t             dec;

  always_comb begin
    dec.character = in_item_i.character;
    dec.cell_addr = ADDR_W'(in_item_i.cell_address);
    dec.in_range  = ({1'b0, in_item_i.cell_address} < 12'(CELL_COUNT));
    unique case (in_item_i.command)
      CMD_PUT: begin
        unique case (in_item_i.character)
          CH_NEWLINE: dec.op = OP_NEWLINE;
          CH_RETURN:  dec.op = OP_RETURN;
          CH_TAB:     dec.op = OP_TAB;
          default:    dec.op = OP_CHAR;
        endcase
      end
      CMD_CLEAR: dec.op = OP_CLEAR;
      CMD_READ:  dec.op = OP_READ;
      default:   dec.op = OP_NOP;
    endcase
  end

  // No beats taken while the back end sweeps the store after reset.
  assign full   = (count_q == QCNT_W'(QUEUE_DEPTH)) || status_i.init_busy;
  assign accept = push && !full;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (accept) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (status_i.take) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (accept && !status_i.take) begin
      count_d = count_q + 1'b1;
    end else if (!accept && status_i.take) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      queue_q[wr_ptr_q] <= dec;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.op    = queue_q[rd_ptr_q];

endmodule

FILE: sv/tcw_back.sv
// Back end: cursor, screen store and the sequencer that runs put, scroll, clear and read.
// Depends on tcw_pkg, tcw_ram and text_console_writer_defines.svh.
`include "text_console_writer_defines.svh"

module tcw_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tcw_pkg::tcw_head_t   head_i,
  input  tcw_pkg::tcw_color_t  color_i,
  output tcw_pkg::tcw_status_t status_o,
  output logic                 empty,
  input  logic                 pop,
  output tcw_pkg::tcw_out_t    out_item_o
);
  import tcw_pkg::*;

  tcw_state_e        state_q, state_d;
  logic [ROW_W-1:0]  line_q, line_d;
  logic [COL_W-1:0]  pos_q, pos_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TAB_W-1:0]  tab_q, tab_d;
  logic              scr_q, scr_d;
  logic              ret_tab_q, ret_tab_d;
  logic              rd_range_q, rd_range_d;
  logic              out_valid_q, out_valid_d;
  tcw_out_t          out_q, out_d;

  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [CELL_W-1:0] wdata, rdata;

  logic              pop_ok, slot_ok, fin, take;
  logic [CELL_W-1:0] fin_data;
  logic [ADDR_W-1:0] cur_addr;
  logic [COL_W-1:0]  pos_inc;
  logic [ROW_W-1:0]  line_inc;
  logic              wrap, last_line, need_scroll;
  logic [CELL_W-1:0] blank;

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELL_COUNT)
  ) u_screen (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign pop_ok  = pop && out_valid_q;
  assign slot_ok = !out_valid_q || pop_ok;
  assign blank   = make_cell(color_i, BLANK_CHAR);

  assign cur_addr    = ADDR_W'(line_q) * ADDR_W'(COLUMNS) + ADDR_W'(pos_q);
  assign pos_inc     = pos_q + 1'b1;
  assign line_inc    = line_q + 1'b1;
  assign wrap        = (pos_inc == COL_W'(COLUMNS));
  assign last_line   = (line_inc == ROW_W'(ROWS));
  assign need_scroll = wrap && last_line;

  always_comb begin
    state_d     = state_q;
    line_d      = line_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    tab_d       = tab_q;
    scr_d       = scr_q;
    ret_tab_d   = ret_tab_q;
    rd_range_d  = rd_range_q;
    out_valid_d = out_valid_q && !pop_ok;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = cur_addr;
    wdata       = blank;
    re          = 1'b0;
    raddr       = head_i.op.cell_addr;
    take        = 1'b0;
    fin         = 1'b0;
    fin_data    = '0;

    unique case (state_q)
      ST_INIT: begin
        // Power-up sweep writes the reset blank, whatever the color registers say.
        we    = 1'b1;
        waddr = ADDR_W'(cnt_q);
        wdata = RESET_BLANK;
        if (cnt_q == CNT_W'(CELL_COUNT - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (head_i.valid && slot_ok) begin
          take  = 1'b1;
          scr_d = 1'b0;
          cnt_d = '0;
          unique case (head_i.op.op)
            OP_CHAR: begin
              we    = 1'b1;
              wdata = make_cell(color_i, head_i.op.character);
              if (!wrap) begin
                pos_d = pos_inc;
                fin   = 1'b1;
              end else if (!last_line) begin
                pos_d  = '0;
                line_d = line_inc;
                fin    = 1'b1;
              end else begin
                pos_d     = '0;
                line_d    = ROW_W'(ROWS - 1);
                scr_d     = 1'b1;
                ret_tab_d = 1'b0;
                state_d   = ST_SCROLL;
              end
            end
            OP_NEWLINE: begin
              pos_d = '0;
              if (last_line) begin
                line_d    = ROW_W'(ROWS - 1);
                scr_d     = 1'b1;
                ret_tab_d = 1'b0;
                state_d   = ST_SCROLL;
              end else begin
                line_d = line_inc;
                fin    = 1'b1;
              end
            end
            OP_RETURN: begin
              pos_d = '0;
              fin   = 1'b1;
            end
            OP_TAB: begin
              tab_d   = TAB_W'(TAB_SPACES);
              state_d = ST_TAB;
            end
            OP_CLEAR: begin
              state_d = ST_CLEAR;
            end
            OP_READ: begin
              re         = 1'b1;
              raddr      = head_i.op.in_range ? head_i.op.cell_addr : '0;
              rd_range_d = head_i.op.in_range;
              state_d    = ST_RDATA;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      ST_TAB: begin
        if (tab_q == '0) begin
          if (slot_ok) begin
            fin     = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          we    = 1'b1;
          tab_d = tab_q - 1'b1;
          if (!wrap) begin
            pos_d = pos_inc;
          end else if (!last_line) begin
            pos_d  = '0;
            line_d = line_inc;
          end else begin
            pos_d     = '0;
            line_d    = ROW_W'(ROWS - 1);
            scr_d     = 1'b1;
            ret_tab_d = 1'b1;
            cnt_d     = '0;
            state_d   = ST_SCROLL;
          end
        end
      end

      ST_SCROLL: begin
        // Read runs one cell ahead of the write: cycle k reads k+COLUMNS, writes k-1.
        re    = (cnt_q < CNT_W'(SCROLL_LAST));
        raddr = ADDR_W'(cnt_q) + ADDR_W'(COLUMNS);
        we    = (cnt_q != '0);
        waddr = ADDR_W'(cnt_q - 1'b1);
        wdata = (cnt_q <= CNT_W'(SCROLL_LAST)) ? rdata : blank;
        if (cnt_q == CNT_W'(CELL_COUNT)) begin
          cnt_d   = '0;
          state_d = ret_tab_q ? ST_TAB : ST_FINISH;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_CLEAR: begin
        we    = 1'b1;
        waddr = ADDR_W'(cnt_q);
        if (cnt_q == CNT_W'(CELL_COUNT - 1)) begin
          cnt_d   = '0;
          line_d  = '0;
          pos_d   = '0;
          state_d = ST_FINISH;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_RDATA: begin
        if (slot_ok) begin
          fin      = 1'b1;
          fin_data = rd_range_q ? rdata : '0;
          state_d  = ST_IDLE;
        end
      end

      ST_FINISH: begin
        if (slot_ok) begin
          fin     = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (fin) begin
      out_valid_d      = 1'b1;
      out_d.row_now    = line_d;
      out_d.column_now = pos_d;
      out_d.cell_data  = fin_data;
      out_d.did_scroll = scr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      line_q      <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
      tab_q       <= '0;
      scr_q       <= 1'b0;
      ret_tab_q   <= 1'b0;
      rd_range_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      line_q      <= line_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      tab_q       <= tab_d;
      scr_q       <= scr_d;
      ret_tab_q   <= ret_tab_d;
      rd_range_q  <= rd_range_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign status_o.take      = take;
  assign status_o.init_busy = (state_q == ST_INIT);
  assign empty              = !out_valid_q;
  assign out_item_o         = out_q;

  `TCW_CHECK(a_cursor_range, (line_q < ROW_W'(ROWS)) && (pos_q < COL_W'(COLUMNS)), "cursor out of range")
  `TCW_CHECK(a_take_idle, take |-> ((state_q == ST_IDLE) && head_i.valid), "op taken while busy")
  `TCW_CHECK(a_no_overwrite, fin |-> slot_ok, "result overwrites a waiting beat")
  `TCW_CHECK(a_sweep_bound, cnt_q <= CNT_W'(CELL_COUNT), "sweep counter past end of store")
  `TCW_CHECK_NEXT(a_init_once, state_q != ST_INIT, state_q != ST_INIT, "reentered init sweep")

endmodule
